// ===== hdl/fd_pkg.sv =====
// Shared types, constants and register indexes for the RGB555 fade block.
package fd_pkg;

    localparam int unsigned CH_W      = 5;
    localparam int unsigned FACTOR_W  = 8;
    localparam int unsigned REM_W     = 13;
    localparam int unsigned COLOR_W   = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned STEP_W    = 3;

    localparam logic [CH_W-1:0]     CH_MAX         = 5'd31;
    localparam logic [STEP_W-1:0]   BOOST_QUARTERS = 3'd4;
    localparam logic [3:0]          COLD_ENTRY_A   = 4'd5;
    localparam logic [3:0]          COLD_ENTRY_B   = 4'd7;
    localparam logic [COLOR_W-1:0]  BLACK          = 15'h0000;
    // floor(x / 10) == (x * 205) >> 11 for every luma sum up to 310
    localparam logic [7:0]          LUMA_RECIP     = 8'd205;
    localparam int unsigned         LUMA_SHIFT     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD  = 3'd4;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  quo;
    } t_lane;

    typedef struct packed {
        logic               byp;
        logic [COLOR_W-1:0] byp_color;
        t_lane [2:0]        lane;
    } t_pipe;

    typedef struct packed {
        logic                 byp;
        logic [COLOR_W-1:0]   byp_color;
        logic [2:0][CH_W-1:0] chan;
        logic [CH_W-1:0]      gray;
    } t_front;

endpackage

// ===== hdl/fd_pix_in_if.sv =====
// Input color channel: valid/ready handshake with color and palette entry.
interface fd_pix_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic [3:0]  entry_index;

    modport source (output valid, output pixel_color, output entry_index, input ready);
    modport sink   (input valid, input pixel_color, input entry_index, output ready);
endinterface

// ===== hdl/fd_pix_out_if.sv =====
// Output color channel: valid/ready handshake with the faded color.
interface fd_pix_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] scaled_color;

    modport source (output valid, output scaled_color, input ready);
    modport sink   (input valid, input scaled_color, output ready);
endinterface

// ===== hdl/fd_front.sv =====
// Front stage logic: cold start, channel split, white boost and luma gray.
module fd_front (
    input  logic [15:0]          i_color,
    input  logic [3:0]           i_entry,
    input  logic                 i_cold,
    input  logic                 i_boost,
    input  logic [2:0]           i_step,
    input  logic                 i_num_zero,
    output fd_pkg::t_front       o_front
);
    import fd_pkg::*;

    logic [COLOR_W-1:0]   color;
    logic [2:0][CH_W-1:0] chan;
    logic [2:0][CH_W-1:0] boosted;
    logic [STEP_W-1:0]    step;
    logic [8:0]           luma_sum;
    logic [16:0]          luma_prod;
    logic [7:0]           dist_prod;

    always_comb begin
        color = i_color[COLOR_W-1:0];
        if (i_cold && (i_entry == COLD_ENTRY_A || i_entry == COLD_ENTRY_B)) begin
            color = BLACK;
        end
        chan[2] = color[14:10];
        chan[1] = color[9:5];
        chan[0] = color[4:0];
        step = (i_step > BOOST_QUARTERS) ? BOOST_QUARTERS : i_step;
        for (int k = 0; k < 3; k++) begin
            dist_prod  = 8'(CH_MAX - chan[k]) * 8'(step);
            boosted[k] = chan[k] + dist_prod[6:2];
        end
        luma_sum  = 9'(chan[2]) * 9'd3 + 9'(chan[1]) * 9'd6 + 9'(chan[0]);
        luma_prod = 17'(luma_sum) * 17'(LUMA_RECIP);

        o_front.chan      = chan;
        o_front.gray      = luma_prod[LUMA_SHIFT +: CH_W];
        o_front.byp       = i_boost || i_num_zero;
        o_front.byp_color = i_boost ? {boosted[2], boosted[1], boosted[0]} : BLACK;
    end
endmodule

// ===== hdl/fd_div_bits.sv =====
// Restoring division steps for three lanes, quotient bits HI down to LO.
module fd_div_bits #(
    parameter int unsigned HI = 4,
    parameter int unsigned LO = 2
) (
    input  fd_pkg::t_lane [2:0] i_lane,
    input  logic [7:0]          i_den,
    output fd_pkg::t_lane [2:0] o_lane
);
    import fd_pkg::*;

    logic [REM_W-1:0] trial;

    always_comb begin
        o_lane = i_lane;
        for (int l = 0; l < 3; l++) begin
            for (int k = HI; k >= int'(LO); k--) begin
                trial = REM_W'(i_den) << k;
                if (o_lane[l].rem >= trial) begin
                    o_lane[l].rem    = o_lane[l].rem - trial;
                    o_lane[l].quo[k] = 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/rgb555_fade_desaturate.sv =====
// Top level: seven-stage pipeline for RGB555 fade, desaturate and white boost.
//  channel   dir  transaction
//  i_pix     in   pixel_color[15:0], entry_index[3:0]
//  o_pix     out  scaled_color[14:0]
//  i_cfg_*   in   register write: index[2:0], data[7:0]
// One color per cycle while o_pix.ready stays high; each channel divides by the
// denominator in two pipelined steps per blend and per scale.
// Synchronous active-low reset empties every stage and loads register defaults.
// Each stage advances when it is empty or the next one advances, so a stall
// fills bubbles first and drops or repeats nothing.
module rgb555_fade_desaturate (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    fd_pix_in_if.sink                  i_pix,
    fd_pix_out_if.source               o_pix
);
    import fd_pkg::*;

    localparam int unsigned NSTG = 7;

    logic [FACTOR_W-1:0] r_num, r_den;
    logic                r_boost, r_cold;
    logic [STEP_W-1:0]   r_step;
    logic [FACTOR_W-1:0] num_eff;

    logic [NSTG:1] r_v;
    logic [NSTG:1] adv;
    t_front        r_f, n_f;
    t_pipe         r_p [2:NSTG];
    t_pipe         n_p2, n_p5;
    t_lane [2:0]   d3, d4, d6, d7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num   <= 8'd4;
            r_den   <= 8'd4;
            r_boost <= 1'b0;
            r_step  <= '0;
            r_cold  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM:   r_num   <= i_cfg_data;
                CFG_DEN:   r_den   <= i_cfg_data;
                CFG_BOOST: r_boost <= i_cfg_data[0];
                CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                CFG_COLD:  r_cold  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign num_eff = (r_num > r_den) ? r_den : r_num;

    // advance chain from the output backward
    always_comb begin
        adv[NSTG] = !r_v[NSTG] || o_pix.ready;
        for (int s = NSTG - 1; s >= 1; s--) begin
            adv[s] = !r_v[s] || adv[s+1];
        end
    end

    assign i_pix.ready = adv[1];

    fd_front u_front (
        .i_color   (i_pix.pixel_color),
        .i_entry   (i_pix.entry_index),
        .i_cold    (r_cold),
        .i_boost   (r_boost),
        .i_step    (r_step),
        .i_num_zero(num_eff == '0),
        .o_front   (n_f)
    );

    // blend numerator: c*num + gray*(den-num)
    always_comb begin
        n_p2.byp       = r_f.byp;
        n_p2.byp_color = r_f.byp_color;
        for (int l = 0; l < 3; l++) begin
            n_p2.lane[l].rem = REM_W'(r_f.chan[l]) * REM_W'(num_eff)
                             + REM_W'(r_f.gray) * REM_W'(r_den - num_eff);
            n_p2.lane[l].quo = '0;
        end
    end

    fd_div_bits #(.HI(4), .LO(2)) u_div_a (.i_lane(r_p[2].lane), .i_den(r_den), .o_lane(d3));
    fd_div_bits #(.HI(1), .LO(0)) u_div_b (.i_lane(r_p[3].lane), .i_den(r_den), .o_lane(d4));

    // scale numerator: blended*num
    always_comb begin
        n_p5.byp       = r_p[4].byp;
        n_p5.byp_color = r_p[4].byp_color;
        for (int l = 0; l < 3; l++) begin
            n_p5.lane[l].rem = REM_W'(r_p[4].lane[l].quo) * REM_W'(num_eff);
            n_p5.lane[l].quo = '0;
        end
    end

    fd_div_bits #(.HI(4), .LO(2)) u_div_c (.i_lane(r_p[5].lane), .i_den(r_den), .o_lane(d6));
    fd_div_bits #(.HI(1), .LO(0)) u_div_d (.i_lane(r_p[6].lane), .i_den(r_den), .o_lane(d7));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) r_v[1] <= i_pix.valid;
            for (int s = 2; s <= NSTG; s++) begin
                if (adv[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) r_f <= n_f;
        if (adv[2]) r_p[2] <= n_p2;
        if (adv[3]) begin
            r_p[3].byp       <= r_p[2].byp;
            r_p[3].byp_color <= r_p[2].byp_color;
            r_p[3].lane      <= d3;
        end
        if (adv[4]) begin
            r_p[4].byp       <= r_p[3].byp;
            r_p[4].byp_color <= r_p[3].byp_color;
            r_p[4].lane      <= d4;
        end
        if (adv[5]) r_p[5] <= n_p5;
        if (adv[6]) begin
            r_p[6].byp       <= r_p[5].byp;
            r_p[6].byp_color <= r_p[5].byp_color;
            r_p[6].lane      <= d6;
        end
        if (adv[7]) begin
            r_p[7].byp       <= r_p[6].byp;
            r_p[7].byp_color <= r_p[6].byp_color;
            r_p[7].lane      <= d7;
        end
    end

    assign o_pix.valid        = r_v[NSTG];
    assign o_pix.scaled_color = r_p[NSTG].byp ? r_p[NSTG].byp_color
                              : {r_p[NSTG].lane[2].quo, r_p[NSTG].lane[1].quo,
                                 r_p[NSTG].lane[0].quo};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG] && !o_pix.ready |=> r_v[NSTG])
        else $error("output stage lost its transaction while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[1] |-> i_pix.ready)
        else $error("input stalled with an empty first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_pix.valid)
        else $error("output valid right after reset");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && !adv[5] |=> r_v[4])
        else $error("mid pipeline transaction dropped during stall");

endmodule

// ===== tb/tb_rgb555_fade_desaturate.sv =====
// Testbench for the RGB555 fade, desaturate and white-boost pipeline.
module tb_rgb555_fade_desaturate;
    import fd_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    fd_pix_in_if  pix_in ();
    fd_pix_out_if pix_out ();

    rgb555_fade_desaturate uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_in.sink),
        .o_pix       (pix_out.source)
    );

    localparam int LATENCY = 7;

    // shadow copy of the register file
    logic [7:0] fade_num;
    logic [7:0] fade_den;
    logic       boost_on;
    logic [2:0] boost_step;
    logic       cold_on;

    logic [COLOR_W-1:0] faded_q[$];
    int                 mismatches;
    int                 bad_extra;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [COLOR_W-1:0] fade_color(logic [15:0] color, logic [3:0] entry);
        int ch[3];
        int num;
        int den;
        int gray;
        int step;
        int blended;
        den = int'(fade_den);
        num = (fade_num > fade_den) ? int'(fade_den) : int'(fade_num);
        if (cold_on && (entry == COLD_ENTRY_A || entry == COLD_ENTRY_B)) color = 16'h0000;
        ch[0] = int'(color[14:10]);
        ch[1] = int'(color[9:5]);
        ch[2] = int'(color[4:0]);
        if (boost_on) begin
            step = (boost_step > 3'd4) ? 4 : int'(boost_step);
            for (int k = 0; k < 3; k++) ch[k] = ch[k] + ((31 - ch[k]) * step) / 4;
        end else if (num == 0) begin
            return BLACK;
        end else begin
            gray = (3 * ch[0] + 6 * ch[1] + ch[2]) / 10;
            for (int k = 0; k < 3; k++) begin
                blended = (ch[k] * num + gray * (den - num)) / den;
                ch[k] = (blended * num) / den;
            end
        end
        return {ch[0][4:0], ch[1][4:0], ch[2][4:0]};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_NUM:   fade_num = data;
            CFG_DEN:   fade_den = data;
            CFG_BOOST: boost_on = data[0];
            CFG_STEP:  boost_step = data[2:0];
            CFG_COLD:  cold_on = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic [7:0] num, logic [7:0] den, logic boost,
                            logic [2:0] step, logic cold);
        write_reg(CFG_NUM, num);
        write_reg(CFG_DEN, den);
        write_reg(CFG_BOOST, {7'd0, boost});
        write_reg(CFG_STEP, {5'd0, step});
        write_reg(CFG_COLD, {7'd0, cold});
    endtask

    task automatic send_color(logic [15:0] color, logic [3:0] entry);
        int gap;
        gap = rand_gap();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.pixel_color <= color;
        pix_in.entry_index <= entry;
        faded_q.push_back(fade_color(color, entry));
        // hold until the edge that accepts the transaction
        @(posedge i_clk iff pix_in.ready);
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (faded_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // output side: random back-pressure and in-order compare
    initial begin
        int stall;
        pix_out.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = rand_gap();
            if (stall == 0 || $urandom_range(0, 3) == 0) pix_out.ready <= 1'b1;
            else begin
                pix_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                pix_out.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic [COLOR_W-1:0] want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (faded_q.size() == 0) begin
                bad_extra++;
                if (mismatches + bad_extra <= 10)
                    $display("unexpected transaction: color %h", pix_out.scaled_color);
            end else begin
                want = faded_q.pop_front();
                if (pix_out.scaled_color !== want) begin
                    mismatches++;
                    if (mismatches + bad_extra <= 10)
                        $display("scaled_color mismatch: expected %h actual %h",
                                 want, pix_out.scaled_color);
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_color(16'h7FFF, 4'd0);
        send_color(16'h0000, 4'd5);
        send_color(16'hFFFF, 4'd15);
        drain();
    endtask

    task automatic test_desaturate_extremes();
        set_mode(8'd1, 8'd255, 1'b0, 3'd0, 1'b0);
        send_color(16'h7FFF, 4'd1);
        send_color(16'h7C00, 4'd2);
        send_color(16'h03E0, 4'd3);
        send_color(16'h001F, 4'd4);
        drain();
        set_mode(8'd255, 8'd255, 1'b0, 3'd0, 1'b0);
        send_color(16'h8000, 4'd0);
        send_color(16'h7FFF, 4'd9);
        drain();
        set_mode(8'd3, 8'd7, 1'b0, 3'd0, 1'b0);
        send_color(16'h5555, 4'd10);
        send_color(16'h2AAA, 4'd11);
        drain();
    endtask

    task automatic test_zero_and_saturation();
        // numerator zero gives black; numerator over denominator passes through
        set_mode(8'd0, 8'd9, 1'b0, 3'd0, 1'b0);
        send_color(16'h7FFF, 4'd6);
        drain();
        set_mode(8'd200, 8'd1, 1'b0, 3'd0, 1'b0);
        send_color(16'h1234, 4'd6);
        send_color(16'h7FFF, 4'd8);
        drain();
    endtask

    task automatic test_white_boost();
        for (int s = 0; s < 8; s++) begin
            set_mode(8'd0, 8'd1, 1'b1, s[2:0], 1'b0);
            send_color(16'h0000, 4'd12);
            send_color(16'h4210, 4'd13);
            drain();
        end
    endtask

    task automatic test_cold_start();
        set_mode(8'd4, 8'd4, 1'b0, 3'd0, 1'b1);
        send_color(16'h7FFF, 4'd5);
        send_color(16'h7FFF, 4'd7);
        send_color(16'h7FFF, 4'd6);
        drain();
        set_mode(8'd4, 8'd4, 1'b1, 3'd2, 1'b1);
        send_color(16'h7FFF, 4'd7);
        drain();
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 15; phase++) begin
            set_mode(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                     1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
            if (phase == 0) set_mode(8'd255, 8'd255, 1'b0, 3'd4, 1'b1);
            if (phase == 1) set_mode(8'd1, 8'd1, 1'b0, 3'd0, 1'b0);
            for (int n = 0; n < 100; n++)
                send_color(16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
            drain();
        end
    endtask

    initial begin
        mismatches         = 0;
        bad_extra          = 0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_NUM;
        i_cfg_data         = 8'd0;
        pix_in.valid       = 1'b0;
        pix_in.pixel_color = 16'd0;
        pix_in.entry_index = 4'd0;
        fade_num   = 8'd4;
        fade_den   = 8'd4;
        boost_on   = 1'b0;
        boost_step = 3'd0;
        cold_on    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_desaturate_extremes();
        test_zero_and_saturation();
        test_white_boost();
        test_cold_start();
        test_random_stream();
        if (mismatches == 0 && bad_extra == 0 && faded_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/fd_pkg.sv
hdl/fd_pix_in_if.sv
hdl/fd_pix_out_if.sv
hdl/fd_front.sv
hdl/fd_div_bits.sv
hdl/rgb555_fade_desaturate.sv
tb/tb_rgb555_fade_desaturate.sv
